>>> rtl/wildcard_byte_pattern_scan_assert.svh
// Assertion macros for the wildcard byte pattern scan block.
// Each macro expects clk_i and rst_ni to be in scope at the point of use.
`ifndef WILDCARD_BYTE_PATTERN_SCAN_ASSERT_SVH
`define WILDCARD_BYTE_PATTERN_SCAN_ASSERT_SVH

// Same-cycle implication, checked outside reset
`define WBPS_ASSERT_COMB(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset
`define WBPS_ASSERT_SEQ(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/wbps_pkg.sv
// Shared types and constants for the wildcard byte pattern scan block.
// No dependencies; used by the interfaces, the lane compare and the top level.
package wbps_pkg;

  // Parameter defaults
  localparam int unsigned MaxPatternDef = 32;
  localparam int unsigned OffsetBitsDef = 32;

  // Fixed field and register widths
  localparam int unsigned PatBytes = 32;
  localparam int unsigned CfgDataW = 64;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned LenW     = 6;
  localparam int unsigned OffsetW  = 32;

  // Configuration register indexes
  typedef enum logic [CfgIdxW-1:0] {
    CfgPatA = 3'd0,
    CfgPatB = 3'd1,
    CfgPatC = 3'd2,
    CfgPatD = 3'd3,
    CfgCare = 3'd4,
    CfgLen  = 3'd5
  } cfg_idx_e;

  // Pattern bytes with their care bits, byte 0 in the low bits
  typedef struct packed {
    logic [PatBytes-1:0][7:0] bytes;
    logic [PatBytes-1:0]      care;
  } pattern_t;

endpackage

>>> rtl/wbps_if.sv
// Valid/ready channels for the byte requests and the scan results.
// Depends on wbps_pkg for the offset width.
interface wbps_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       end_of_image;

  modport source (output valid, output data_byte, output end_of_image, input ready);
  modport sink   (input valid, input data_byte, input end_of_image, output ready);
endinterface

interface wbps_out_if;
  logic                         valid;
  logic                         ready;
  logic                         found;
  logic [wbps_pkg::OffsetW-1:0] match_offset;

  modport source (output valid, output found, output match_offset, input ready);
  modport sink   (input valid, input found, input match_offset, output ready);
endinterface

>>> rtl/wbps_match.sv
// Parallel masked compare of the byte window against the pattern.
// Depends on wbps_pkg for the pattern type.
module wbps_match #(
  parameter int unsigned MAX_PATTERN = wbps_pkg::MaxPatternDef
) (
  input  wbps_pkg::pattern_t                     pattern_i,
  input  logic [MAX_PATTERN-1:0][7:0]            window_i,
  input  logic [$clog2(MAX_PATTERN+1)-1:0]       len_i,
  output logic                                   hit_o
);
  import wbps_pkg::*;

  localparam int unsigned LW = $clog2(MAX_PATTERN + 1);
  localparam int unsigned IW = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
  localparam int unsigned NL = (MAX_PATTERN < PatBytes) ? MAX_PATTERN : PatBytes;

  logic [NL-1:0] mismatch;

  // One lane per pattern byte: pattern byte j lines up with window entry len-1-j
  for (genvar j = 0; j < NL; j++) begin : g_lane
    localparam logic [LW-1:0] LaneIdx = LW'(j);
    logic          active;
    logic [LW-1:0] pos_full;
    logic [IW-1:0] pos;

    assign active   = len_i > LaneIdx;
    assign pos_full = len_i - LW'(1) - LaneIdx;
    assign pos      = IW'(pos_full);
    assign mismatch[j] = active && pattern_i.care[j] &&
                         (window_i[pos] != pattern_i.bytes[j]);
  end

  assign hit_o = ~|mismatch;

endmodule

>>> rtl/wildcard_byte_pattern_scan.sv
// Wildcard byte pattern scan: top level with registers, window, count and result stage.
// Depends on wbps_pkg, wbps_if.sv, wbps_match and the assertion macro header.
//
// Searches an image, streamed one byte per request, for the first occurrence of a
// pattern of up to 32 bytes in which each byte is either compared or a wildcard.
// One byte is taken every clock cycle; the whole window compare runs in the cycle
// the byte is accepted and its result is in the output register in the next cycle.
// The only thing that holds off a byte is a result that waits in the output register
// and is not taken in that cycle. A match gives one found result with the start
// offset (byte count minus pattern length, count saturating at its maximum); an image
// that ends without a match gives one not-found result with offset zero. The user must
// write config on the plain write port only while no image is in flight; not enforced.
`include "wildcard_byte_pattern_scan_assert.svh"

module wildcard_byte_pattern_scan #(
  parameter int unsigned MAX_PATTERN = wbps_pkg::MaxPatternDef,
  parameter int unsigned OFFSET_BITS = wbps_pkg::OffsetBitsDef
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [wbps_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [wbps_pkg::CfgDataW-1:0]  cfg_data_i,
  wbps_in_if.sink                        req_i,
  wbps_out_if.source                     res_o
);
  import wbps_pkg::*;

  localparam int unsigned LW = $clog2(MAX_PATTERN + 1);
  localparam logic [LenW:0] MaxLen = (LenW + 1)'(MAX_PATTERN);

  // Configuration registers
  pattern_t            pat_q;
  logic [LenW-1:0]     len_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pat_q <= '0;
      len_q <= LenW'(1);
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CfgPatA: pat_q.bytes[7:0]   <= cfg_data_i;
        CfgPatB: pat_q.bytes[15:8]  <= cfg_data_i;
        CfgPatC: pat_q.bytes[23:16] <= cfg_data_i;
        CfgPatD: pat_q.bytes[31:24] <= cfg_data_i;
        CfgCare: pat_q.care         <= cfg_data_i[PatBytes-1:0];
        CfgLen:  len_q              <= cfg_data_i[LenW-1:0];
        default: ;
      endcase
    end
  end

  // Effective length: zero acts as one, clamp at the window depth
  logic [LenW:0]   len_clamp;
  logic [LW-1:0]   len_eff;

  always_comb begin
    if (len_q == '0) begin
      len_clamp = (LenW + 1)'(1);
    end else if ({1'b0, len_q} > MaxLen) begin
      len_clamp = MaxLen;
    end else begin
      len_clamp = {1'b0, len_q};
    end
  end
  assign len_eff = LW'(len_clamp);

  // Handshake
  logic out_vld_q;
  logic accept;

  assign req_i.ready = !out_vld_q || res_o.ready;
  assign accept      = req_i.valid && req_i.ready;

  // Window with the new byte shifted in
  logic [MAX_PATTERN-1:0][7:0] win_q;
  logic [MAX_PATTERN-1:0][7:0] win_shift;

  always_comb begin
    win_shift[0] = req_i.data_byte;
    for (int k = 1; k < MAX_PATTERN; k++) begin
      win_shift[k] = win_q[k-1];
    end
  end

  // Window entries are only read once filled in this image, so no reset
  always_ff @(posedge clk_i) begin
    if (accept) begin
      win_q <= win_shift;
    end
  end

  // Saturating byte count
  logic [OFFSET_BITS-1:0] seen_q;
  logic [OFFSET_BITS-1:0] seen_inc;
  logic [OFFSET_BITS-1:0] len_wide;
  logic [OFFSET_BITS-1:0] offset_full;

  assign seen_inc    = (seen_q == '1) ? seen_q : seen_q + OFFSET_BITS'(1);
  assign len_wide    = OFFSET_BITS'(len_eff);
  assign offset_full = seen_inc - len_wide;

  // Lane compare
  logic lane_hit;

  wbps_match #(
    .MAX_PATTERN (MAX_PATTERN)
  ) u_match (
    .pattern_i (pat_q),
    .window_i  (win_shift),
    .len_i     (len_eff),
    .hit_o     (lane_hit)
  );

  logic rep_q;
  logic hit;
  logic produce;

  assign hit     = !rep_q && (seen_inc >= len_wide) && lane_hit;
  assign produce = hit || (req_i.end_of_image && !rep_q);

  // Per-image state, cleared after the last byte
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seen_q <= '0;
      rep_q  <= 1'b0;
    end else if (accept) begin
      if (req_i.end_of_image) begin
        seen_q <= '0;
        rep_q  <= 1'b0;
      end else begin
        seen_q <= seen_inc;
        rep_q  <= rep_q || hit;
      end
    end
  end

  // Result register
  logic               found_q;
  logic [OffsetW-1:0] off_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (accept && produce) begin
      out_vld_q <= 1'b1;
    end else if (res_o.ready) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && produce) begin
      found_q <= hit;
      off_q   <= hit ? OffsetW'(offset_full) : '0;
    end
  end

  assign res_o.valid        = out_vld_q;
  assign res_o.found        = found_q;
  assign res_o.match_offset = off_q;

  // Checks
  `WBPS_ASSERT_COMB(a_notfound_zero, out_vld_q && !found_q, off_q == '0, "not-found offset not zero")
  `WBPS_ASSERT_SEQ(a_eoi_clears, accept && req_i.end_of_image, seen_q == '0 && !rep_q, "image state not cleared")
  `WBPS_ASSERT_SEQ(a_hit_sticks, accept && !req_i.end_of_image && hit, rep_q, "match not recorded")
  `WBPS_ASSERT_COMB(a_rep_count, rep_q, seen_q != '0, "match recorded with empty count")

endmodule

>>> test/wildcard_byte_pattern_scan_test.sv
// Self-checking testbench for wildcard_byte_pattern_scan: random images scanned for masked signatures.
// Depends on wbps_pkg, the channel interfaces in wbps_if.sv and the scan block itself.
module wildcard_byte_pattern_scan_test;
  timeunit 1ns;
  timeprecision 1ps;
  import wbps_pkg::*;

  localparam int unsigned HoldCycles = 300;
  localparam int unsigned ItemGoal   = 1850;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } byte_req_t;

  typedef struct packed {
    logic               found;
    logic [OffsetW-1:0] offset;
  } scan_result_t;

  typedef enum int {ImgMatch, ImgNear, ImgNoise} img_kind_e;

  logic                clk_i;
  logic                rst_ni;
  logic                cfg_we;
  cfg_idx_e            cfg_idx;
  logic [CfgDataW-1:0] cfg_data;

  wbps_in_if  req_if();
  wbps_out_if res_if();

  wildcard_byte_pattern_scan dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data),
    .req_i      (req_if),
    .res_o      (res_if)
  );

  // Signature configuration as the block should hold it
  logic [PatBytes-1:0][7:0]      sig_bytes;
  logic [31:0]                   sig_care;
  logic [LenW-1:0]               sig_len;
  // Scan state: recent[k] is the byte seen k requests ago
  logic [MaxPatternDef-1:0][7:0] recent;
  logic [OffsetW-1:0]            byte_count;
  bit                            hit_seen;

  byte_req_t    byte_q[$];
  scan_result_t result_q[$];
  int unsigned  queued;
  int unsigned  fail_count;
  int unsigned  hold_cnt;
  bit           calm;
  bit           long_hold;
  bit           req_fire;

  // Clock
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Run limit
  initial begin
    #5ms;
    $display("TEST FAILED");
    $finish;
  end

  // Pattern length in use after clamping
  function automatic int unsigned sig_span();
    if (sig_len == 0) return 1;
    if (sig_len > MaxPatternDef) return MaxPatternDef;
    return sig_len;
  endfunction

  // Predict the outcome of one accepted image byte
  function automatic void scan_byte(input logic [7:0] b, input logic last);
    int unsigned  span;
    bit           hit;
    scan_result_t r;
    span = sig_span();
    recent = {recent[MaxPatternDef-2:0], b};
    if (byte_count != '1) byte_count++;
    if (!hit_seen && byte_count >= span) begin
      hit = 1'b1;
      for (int j = 0; j < span; j++)
        if (sig_care[j] && recent[span-1-j] != sig_bytes[j]) hit = 1'b0;
      if (hit) begin
        hit_seen = 1'b1;
        r.found  = 1'b1;
        r.offset = byte_count - OffsetW'(span);
        result_q.insert(result_q.size(), r);
      end
    end
    if (last) begin
      if (!hit_seen) begin
        r = '0;
        result_q.insert(result_q.size(), r);
      end
      recent     = '0;
      byte_count = '0;
      hit_seen   = 1'b0;
    end
  endfunction

  function automatic void log_mismatch(input string what, input scan_result_t want,
                                       input scan_result_t got);
    fail_count++;
    if (fail_count <= 10)
      $display("%0t: %s: expected found=%0b offset=%0d, got found=%0b offset=%0d",
               $time, what, want.found, want.offset, got.found, got.offset);
  endfunction

  // Check results and track accepted requests
  always @(posedge clk_i) begin
    scan_result_t want;
    scan_result_t got;
    req_fire <= req_if.valid && req_if.ready;
    if (rst_ni) begin
      if (res_if.valid && res_if.ready) begin
        got.found  = res_if.found;
        got.offset = res_if.match_offset;
        if (result_q.size() == 0) begin
          log_mismatch("unexpected result", '0, got);
        end else begin
          want = result_q.pop_front();
          if (got.found !== want.found || got.offset !== want.offset)
            log_mismatch("result mismatch", want, got);
        end
      end
      if (req_if.valid && req_if.ready) scan_byte(req_if.data_byte, req_if.end_of_image);
    end
  end

  // Request driver: holds a request until taken, idles at random
  always @(negedge clk_i) begin
    byte_req_t nxt;
    if (!req_if.valid || req_fire) begin
      if (rst_ni && byte_q.size() > 0 && (calm || $urandom_range(99) >= 24)) begin
        nxt = byte_q.pop_front();
        req_if.valid        <= 1'b1;
        req_if.data_byte    <= nxt.data;
        req_if.end_of_image <= nxt.last;
      end else begin
        req_if.valid        <= 1'b0;
        req_if.data_byte    <= 8'($urandom);
        req_if.end_of_image <= 1'b0;
      end
    end
  end

  // Result receiver: random stalls, plus one long hold-off when asked
  always @(negedge clk_i) begin
    if (long_hold && hold_cnt < HoldCycles) begin
      res_if.ready <= 1'b0;
      hold_cnt     <= hold_cnt + 1;
    end else begin
      if (!long_hold) hold_cnt <= 0;
      res_if.ready <= calm || $urandom_range(99) >= 24;
    end
  end

  task automatic write_reg(input cfg_idx_e idx, input logic [CfgDataW-1:0] val);
    @(negedge clk_i);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= val;
    @(negedge clk_i);
    cfg_we <= 1'b0;
    case (idx)
      CfgPatA: sig_bytes[7:0]   = val;
      CfgPatB: sig_bytes[15:8]  = val;
      CfgPatC: sig_bytes[23:16] = val;
      CfgPatD: sig_bytes[31:24] = val;
      CfgCare: sig_care         = val[31:0];
      CfgLen:  sig_len          = val[LenW-1:0];
      default: ;
    endcase
  endtask

  task automatic push_byte(input logic [7:0] b, input logic last);
    byte_req_t r;
    r.data = b;
    r.last = last;
    byte_q.insert(byte_q.size(), r);
    queued++;
  endtask

  // One image: random lead-in, optionally the signature (maybe spoilt), random tail
  task automatic queue_image(input img_kind_e kind, input int unsigned lead,
                             input int unsigned tail);
    logic [7:0]  img[$];
    int unsigned span;
    int unsigned pick;
    logic [63:0] span_mask;
    span      = sig_span();
    span_mask = (64'd1 << span) - 1;
    repeat (lead) img.insert(img.size(), 8'($urandom));
    if (kind != ImgNoise) begin
      for (int j = 0; j < span; j++)
        img.insert(img.size(), sig_care[j] ? sig_bytes[j] : 8'($urandom));
      if (kind == ImgNear && (64'(sig_care) & span_mask) != 0) begin
        do pick = $urandom_range(span - 1); while (!sig_care[pick]);
        img[lead+pick] = img[lead+pick] ^ 8'($urandom_range(255, 1));
      end
    end
    repeat (tail) img.insert(img.size(), 8'($urandom));
    if (img.size() == 0) img.insert(0, 8'($urandom));
    foreach (img[i]) push_byte(img[i], i == img.size() - 1);
  endtask

  // Wait until every request is taken and every result has come back
  task automatic drain();
    while (byte_q.size() != 0 || req_if.valid || result_q.size() != 0)
      @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // Stimulus
  initial begin
    int unsigned      phase;
    int unsigned      phase_end;
    int unsigned      roll;
    logic [CfgDataW-1:0] word;
    logic [31:0]      care;
    logic [LenW-1:0]  len;
    img_kind_e        kind;

    rst_ni              = 1'b0;
    cfg_we              = 1'b0;
    cfg_idx             = CfgPatA;
    cfg_data            = '0;
    req_if.valid        = 1'b0;
    req_if.data_byte    = '0;
    req_if.end_of_image = 1'b0;
    res_if.ready        = 1'b0;
    sig_bytes           = '0;
    sig_care            = '0;
    sig_len             = LenW'(1);
    recent              = '0;
    byte_count          = '0;
    hit_seen            = 1'b0;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed: signature DE AD ?? EF
    write_reg(CfgPatA, 64'h0000_0000_EF00_ADDE);
    write_reg(CfgCare, 64'h0000_000B);
    write_reg(CfgLen, 64'd4);
    // image shorter than the signature, byte extremes
    push_byte(8'h00, 1'b0);
    push_byte(8'hFF, 1'b1);
    // match completing on the last byte
    push_byte(8'hDE, 1'b0);
    push_byte(8'hAD, 1'b0);
    push_byte(8'h55, 1'b0);
    push_byte(8'hEF, 1'b1);
    // two matches in one image, only the first is reported
    push_byte(8'h11, 1'b0);
    push_byte(8'hDE, 1'b0);
    push_byte(8'hAD, 1'b0);
    push_byte(8'h00, 1'b0);
    push_byte(8'hEF, 1'b0);
    push_byte(8'h22, 1'b0);
    push_byte(8'hDE, 1'b0);
    push_byte(8'hAD, 1'b0);
    push_byte(8'h11, 1'b0);
    push_byte(8'hEF, 1'b0);
    push_byte(8'h33, 1'b1);
    // single-byte image, no match
    push_byte(8'hFF, 1'b1);
    drain();
    // zero length behaves as one byte
    write_reg(CfgPatA, 64'h0);
    write_reg(CfgCare, 64'h1);
    write_reg(CfgLen, 64'd0);
    push_byte(8'h05, 1'b0);
    push_byte(8'h05, 1'b0);
    push_byte(8'h00, 1'b1);
    drain();

    // Random phases, each with its own signature set-up
    phase = 0;
    while (queued < ItemGoal) begin
      case (phase)
        0: begin care = '1; len = LenW'(32); end
        1: begin care = '0; len = LenW'(63); end
        2: begin care = $urandom; len = '0; end
        3: begin care = $urandom; len = LenW'($urandom_range(3, 1)); end
        default: begin
          case ($urandom_range(7))
            0: care = '0;
            1: care = '1;
            2: care = $urandom & $urandom & $urandom;
            default: care = $urandom;
          endcase
          case ($urandom_range(9))
            0: len = '0;
            1: len = LenW'(1);
            2: len = LenW'(32);
            3: len = LenW'($urandom_range(63, 33));
            4: len = LenW'($urandom_range(31, 13));
            default: len = LenW'($urandom_range(12, 2));
          endcase
        end
      endcase
      for (int i = 0; i < 4; i++) begin
        roll = $urandom_range(9);
        if (phase == 0 || (phase > 3 && roll == 0)) word = '1;
        else if (phase == 1 || (phase > 3 && roll == 1)) word = '0;
        else word = {$urandom, $urandom};
        write_reg(cfg_idx_e'(CfgPatA + i), word);
      end
      write_reg(CfgCare, CfgDataW'(care));
      write_reg(CfgLen, CfgDataW'(len));

      // phase 3 backs up the result side, phase 4 runs with no idling
      long_hold = (phase == 3);
      calm      = (phase == 4);
      phase_end = queued + 160;
      while (queued < phase_end) begin
        roll = $urandom_range(99);
        kind = roll < 60 ? ImgMatch : (roll < 80 ? ImgNear : ImgNoise);
        if (phase == 3) queue_image(kind, $urandom_range(2), 0);
        else queue_image(kind, $urandom_range(8), $urandom_range(4));
      end
      drain();
      long_hold = 1'b0;
      calm      = 1'b0;
      phase++;
    end

    repeat (8) @(posedge clk_i);
    fail_count += result_q.size();
    if (fail_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
